[rtl/dsn_pkg.sv]
// ----------------------------------------------------------------------------
// dsn_pkg
// shared constants and controller/datapath interface types for the
// double square root block
// ----------------------------------------------------------------------------
package dsn_pkg;

    localparam int FRAC_W    = 52;
    localparam int SIG_W     = 53;
    localparam int EXP_W     = 11;
    localparam int DIV_STEPS = 54;

    localparam logic [EXP_W-1:0]  EXP_BIAS = 11'h3ff;
    localparam logic [EXP_W-1:0]  EXP_MAX  = 11'h7ff;

    // fraction fields of 1.2071067811865475244 and 1.7071067811865475244
    localparam logic [FRAC_W-1:0] SEED_ODD_FRAC  = 52'h3504f333f9de6;
    localparam logic [FRAC_W-1:0] SEED_EVEN_FRAC = 52'hb504f333f9de6;

    typedef struct packed {
        logic load;
        logic div_start;
        logic align;
        logic sum;
        logic emit;
    } dsn_cmd_t;

    typedef struct packed {
        logic special;
        logic div_done;
    } dsn_stat_t;

endpackage

[rtl/dsn_div.sv]
// ----------------------------------------------------------------------------
// dsn_div
// radix-2 restoring divider for positive normal doubles, round to nearest even
// ----------------------------------------------------------------------------
module dsn_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dsn_pkg::EXP_W-1:0]   num_exp,
    input  logic [dsn_pkg::SIG_W-1:0]   num_sig,
    input  logic [dsn_pkg::EXP_W-1:0]   den_exp,
    input  logic [dsn_pkg::SIG_W-1:0]   den_sig,
    output logic                        done,
    output logic [dsn_pkg::EXP_W-1:0]   q_exp,
    output logic [dsn_pkg::SIG_W-1:0]   q_sig
);
    import dsn_pkg::*;

    logic               busy_reg, busy_next;
    logic               rnd_reg, rnd_next;
    logic               done_reg, done_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [SIG_W+1:0]   rem_reg, rem_next;
    logic [SIG_W:0]     quo_reg, quo_next;
    logic [SIG_W-1:0]   den_reg, den_next;
    logic [EXP_W:0]     exp_reg, exp_next;
    logic [EXP_W-1:0]   q_exp_reg, q_exp_next;
    logic [SIG_W-1:0]   q_sig_reg, q_sig_next;

    logic               lt;
    logic               ge;
    logic [SIG_W+1:0]   diff;
    logic               up;
    logic [SIG_W:0]     rsum;

    always_comb
    begin
        busy_next  = busy_reg;
        rnd_next   = 1'b0;
        done_next  = rnd_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        exp_next   = exp_reg;
        q_exp_next = q_exp_reg;
        q_sig_next = q_sig_reg;

        lt   = (num_sig < den_sig);
        ge   = (rem_reg >= {2'b00, den_reg});
        diff = ge ? (rem_reg - {2'b00, den_reg}) : rem_reg;
        up   = quo_reg[0] & ((|rem_reg) | quo_reg[1]);
        rsum = {1'b0, quo_reg[SIG_W:1]} + {{SIG_W{1'b0}}, up};

        if (start)
        begin
            // numerator doubled when below the divisor keeps the quotient in [1,2)
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            rem_next  = lt ? {1'b0, num_sig, 1'b0} : {2'b00, num_sig};
            quo_next  = '0;
            den_next  = den_sig;
            exp_next  = {1'b0, num_exp} - {1'b0, den_exp} + {1'b0, EXP_BIAS}
                        - {{EXP_W{1'b0}}, lt};
        end
        else if (busy_reg)
        begin
            rem_next = {diff[SIG_W:0], 1'b0};
            quo_next = {quo_reg[SIG_W-1:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                rnd_next  = 1'b1;
            end
        end

        if (rnd_reg)
        begin
            if (rsum[SIG_W])
            begin
                q_sig_next = {1'b1, {FRAC_W{1'b0}}};
                q_exp_next = exp_reg[EXP_W-1:0] + 11'd1;
            end
            else
            begin
                q_sig_next = rsum[SIG_W-1:0];
                q_exp_next = exp_reg[EXP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        exp_reg   <= exp_next;
        q_exp_reg <= q_exp_next;
        q_sig_reg <= q_sig_next;
    end

    assign done  = done_reg;
    assign q_exp = q_exp_reg;
    assign q_sig = q_sig_reg;

endmodule

[rtl/dsn_dp.sv]
// ----------------------------------------------------------------------------
// dsn_dp
// operand decode, estimate registers, divider and add-halve unit
// ----------------------------------------------------------------------------
module dsn_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  dsn_pkg::dsn_cmd_t   cmd,
    input  logic [63:0]         operand_bits,
    output dsn_pkg::dsn_stat_t  stat,
    output logic [63:0]         root_bits,
    output logic                unsupported_input
);
    import dsn_pkg::*;

    logic               special_reg, special_next;
    logic               unsup_reg, unsup_next;
    logic [EXP_W-1:0]   new_exp_reg, new_exp_next;
    logic [EXP_W-1:0]   m_exp_reg, m_exp_next;
    logic [SIG_W-1:0]   m_sig_reg, m_sig_next;
    logic [EXP_W-1:0]   est_exp_reg, est_exp_next;
    logic [SIG_W-1:0]   est_sig_reg, est_sig_next;
    logic [EXP_W-1:0]   big_exp_reg, big_exp_next;
    logic [SIG_W-1:0]   big_sig_reg, big_sig_next;
    logic [SIG_W+1:0]   small_reg, small_next;
    logic               st_reg, st_next;
    logic [63:0]        root_reg, root_next;
    logic               flag_reg, flag_next;

    logic               div_done;
    logic [EXP_W-1:0]   q_exp;
    logic [SIG_W-1:0]   q_sig;

    logic [EXP_W-1:0]   e_in;
    logic [EXP_W-1:0]   e_adj;
    logic [EXP_W:0]     e_sum;
    logic               is_zero;
    logic               bad;
    logic               q_big;
    logic [EXP_W-1:0]   d;
    logic [SIG_W-1:0]   b_sig;
    logic [SIG_W+63:0]  shifted;
    logic [SIG_W+2:0]   s;
    logic [SIG_W-1:0]   sig;
    logic               rb;
    logic               sb;
    logic               up;
    logic [SIG_W:0]     rsum;
    logic [EXP_W-1:0]   e_norm;

    dsn_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_exp (m_exp_reg),
        .num_sig (m_sig_reg),
        .den_exp (est_exp_reg),
        .den_sig (est_sig_reg),
        .done    (div_done),
        .q_exp   (q_exp),
        .q_sig   (q_sig)
    );

    always_comb
    begin
        special_next = special_reg;
        unsup_next   = unsup_reg;
        new_exp_next = new_exp_reg;
        m_exp_next   = m_exp_reg;
        m_sig_next   = m_sig_reg;
        est_exp_next = est_exp_reg;
        est_sig_next = est_sig_reg;
        big_exp_next = big_exp_reg;
        big_sig_next = big_sig_reg;
        small_next   = small_reg;
        st_next      = st_reg;
        root_next    = root_reg;
        flag_next    = flag_reg;

        // operand decode
        e_in    = operand_bits[62:52];
        is_zero = (operand_bits[62:0] == 63'd0);
        bad     = operand_bits[63] | (e_in == '0) | (e_in == EXP_MAX);
        e_adj   = e_in[0] ? e_in : (e_in - 11'd1);
        e_sum   = {1'b0, e_adj} + {1'b0, EXP_BIAS};

        // alignment: larger exponent goes first
        q_big   = (q_exp >= est_exp_reg);
        d       = q_big ? (q_exp - est_exp_reg) : (est_exp_reg - q_exp);
        b_sig   = q_big ? est_sig_reg : q_sig;
        shifted = {b_sig, 64'd0} >> d[5:0];

        // add, normalise, round, halve
        s = {1'b0, big_sig_reg, 2'b00} + {1'b0, small_reg};
        if (s[SIG_W+2])
        begin
            sig    = s[SIG_W+2:3];
            rb     = s[2];
            sb     = s[1] | s[0] | st_reg;
            e_norm = big_exp_reg;
        end
        else
        begin
            sig    = s[SIG_W+1:2];
            rb     = s[1];
            sb     = s[0] | st_reg;
            e_norm = big_exp_reg - 11'd1;
        end
        up   = rb & (sb | sig[0]);
        rsum = {1'b0, sig} + {{SIG_W{1'b0}}, up};

        if (cmd.load)
        begin
            special_next = is_zero | bad;
            unsup_next   = ~is_zero & bad;
            new_exp_next = e_sum[EXP_W:1];
            m_sig_next   = {1'b1, operand_bits[51:0]};
            m_exp_next   = e_in[0] ? EXP_BIAS : (EXP_BIAS + 11'd1);
            est_exp_next = EXP_BIAS;
            est_sig_next = {1'b1, e_in[0] ? SEED_ODD_FRAC : SEED_EVEN_FRAC};
        end

        if (cmd.align)
        begin
            big_exp_next = q_big ? q_exp : est_exp_reg;
            big_sig_next = q_big ? q_sig : est_sig_reg;
            if (d[EXP_W-1:6] != '0)
            begin
                small_next = '0;
                st_next    = 1'b1;
            end
            else
            begin
                small_next = shifted[SIG_W+63:62];
                st_next    = |shifted[61:0];
            end
        end

        if (cmd.sum)
        begin
            if (rsum[SIG_W])
            begin
                est_sig_next = {1'b1, {FRAC_W{1'b0}}};
                est_exp_next = e_norm + 11'd1;
            end
            else
            begin
                est_sig_next = rsum[SIG_W-1:0];
                est_exp_next = e_norm;
            end
        end

        if (cmd.emit)
        begin
            root_next = special_reg ? 64'd0
                                    : {1'b0, new_exp_reg, est_sig_reg[FRAC_W-1:0]};
            flag_next = unsup_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        special_reg <= special_next;
        unsup_reg   <= unsup_next;
        new_exp_reg <= new_exp_next;
        m_exp_reg   <= m_exp_next;
        m_sig_reg   <= m_sig_next;
        est_exp_reg <= est_exp_next;
        est_sig_reg <= est_sig_next;
        big_exp_reg <= big_exp_next;
        big_sig_reg <= big_sig_next;
        small_reg   <= small_next;
        st_reg      <= st_next;
        root_reg    <= root_next;
        flag_reg    <= flag_next;
    end

    assign stat.special  = special_reg;
    assign stat.div_done = div_done;
    assign root_bits         = root_reg;
    assign unsupported_input = flag_reg;

endmodule

[rtl/dsn_ctrl.sv]
// ----------------------------------------------------------------------------
// dsn_ctrl
// sequencer for decode, newton steps and result hand-off
// ----------------------------------------------------------------------------
module dsn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          iteration_count,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dsn_pkg::dsn_stat_t  stat,
    output dsn_pkg::dsn_cmd_t   cmd
);
    import dsn_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_ALIGN    = 3'd4;
    localparam logic [2:0] S_SUM      = 3'd5;
    localparam logic [2:0] S_FIN      = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        in_ready    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = iteration_count;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = (stat.special || cnt_reg == 4'd0) ? S_FIN : S_DIV_GO;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = cnt_reg - 4'd1;
                state_next = (cnt_reg == 4'd1) ? S_FIN : S_DIV_GO;
            end
            S_FIN:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ovalid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : ovalid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!ovalid_reg || out_ready))
        else $error("result overwritten while waiting");

    // a loaded word is always checked next
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_CHECK))
        else $error("load not followed by check");

    // the last newton step always leads to the result
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sum && cnt_reg == 4'd1) |=> (state_reg == S_FIN))
        else $error("step count overrun");

    // the divider only finishes while it is awaited
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == S_DIV_WAIT))
        else $error("unexpected divider completion");

endmodule

[rtl/double_sqrt_newton.sv]
// ----------------------------------------------------------------------------
// double_sqrt_newton
// newton-raphson square root of an ieee double bit pattern
// ----------------------------------------------------------------------------
// one word in, one word out. the significand is taken in [1,2), doubled to
// [2,4) for an even biased exponent, and a fixed seed is refined
// iteration_count times by est = (est + m/est)/2 in round-to-nearest-even
// double arithmetic; the halved exponent is then written over the estimate's
// exponent field. zero gives +0; negative, subnormal, infinite and nan words
// give zero with the unsupported flag set. one word is worked on at a time:
// each newton step runs the shared radix-2 divider, which retires one
// quotient bit per cycle and then rounds, followed by an align step and an
// add-halve step; the iteration count resets to 4. special words and a
// count of zero skip the newton steps. the output register lets the next
// word enter while a result waits.
// ----------------------------------------------------------------------------
module double_sqrt_newton (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: iteration_count
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] operand_bits
    // result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] root_bits
    output logic        m_axis_tuser    // [0] unsupported_input
);
    import dsn_pkg::*;

    // newton step count, reset to four
    logic [3:0] iter_reg, iter_next;

    dsn_cmd_t  cmd;
    dsn_stat_t stat;

    always_comb
    begin
        iter_next = cfg_wr_en ? cfg_wr_data : iter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= 4'd4;
        else
            iter_reg <= iter_next;
    end

    // sequencer: decode, divide, align, add-halve, hand-off
    dsn_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .iteration_count (iter_reg),
        .in_valid        (s_axis_tvalid),
        .in_ready        (s_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .stat            (stat),
        .cmd             (cmd)
    );

    // arithmetic and result register
    dsn_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .operand_bits      (s_axis_tdata),
        .stat              (stat),
        .root_bits         (m_axis_tdata),
        .unsupported_input (m_axis_tuser)
    );

endmodule
